FILE: rtl/core/ipl_pkg.sv
// Package: shared constants, codes and types of the address range lookup.
package ipl_pkg;

   // Table geometry
   localparam int TABLE_DEPTH = 1024;
   localparam int SLOT_W      = $clog2(TABLE_DEPTH);
   localparam int COUNT_W     = 11;
   localparam int IDX_W       = COUNT_W + 1;
   localparam int ADDR_W      = 32;
   localparam int OFF_W       = 24;
   localparam int STATUS_W    = 2;

   // CSR port geometry
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 3;

   // Register index, taken from paddr[2]
   localparam logic REG_ENTRY_COUNT = 1'b0;

   // Input item operations
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_FOUND  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_BELOW  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BEYOND = 2'd2;

   // One table row
   typedef struct packed {
      logic [ADDR_W-1:0] range_start;
      logic [ADDR_W-1:0] range_end;
      logic [OFF_W-1:0]  location_offset;
   } row_type;

   // Table access request from the sequencer
   typedef struct packed {
      logic              wr_en;
      logic              rd_en;
      logic [SLOT_W-1:0] addr;
      row_type           row;
   } mem_req_type;

endpackage

FILE: rtl/core/ipl_if.sv
// Interfaces: request and response channels of the address range lookup.
interface ipl_req_if;
   logic                         valid;
   logic                         ready;
   logic                         opcode;
   logic [ipl_pkg::SLOT_W-1:0]   entry_slot;
   logic [ipl_pkg::ADDR_W-1:0]   range_start;
   logic [ipl_pkg::ADDR_W-1:0]   range_end;
   logic [ipl_pkg::OFF_W-1:0]    location_offset;
   logic [ipl_pkg::ADDR_W-1:0]   query_address;

   modport source (output valid, opcode, entry_slot, range_start, range_end,
                   location_offset, query_address, input ready);
   modport sink   (input valid, opcode, entry_slot, range_start, range_end,
                   location_offset, query_address, output ready);
endinterface

interface ipl_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [ipl_pkg::STATUS_W-1:0] status;
   logic [ipl_pkg::SLOT_W-1:0]   match_slot;
   logic [ipl_pkg::OFF_W-1:0]    match_offset;

   modport source (output valid, status, match_slot, match_offset, input ready);
   modport sink   (input valid, status, match_slot, match_offset, output ready);
endinterface

FILE: rtl/core/ip_range_lookup_top.sv
// Top level: address range lookup with a sequenced binary search.
//
//  Channel   Dir   Handshake        Moves
//  req_chan  in    valid/ready      load entry or query address
//  rsp_chan  out   valid/ready      status, match_slot, match_offset
//  csr_*     in    APB psel/penable entry_count register
//
//  A load is written into the table on its transfer.
//  A query runs search probes (up to 11 at 1024 entries), each one
//  table read plus one compare; the end fetch and check reuse both.
//  Below the first entry the end fetch is skipped; at zero count, the probes too.
//  Reset is synchronous; it clears the sequencer, result valid and count, not
//  the table. A stalled result holds; loads are taken, a finished query waits.
module ip_range_lookup_top (
   input  logic                            clock,
   input  logic                            reset,
   ipl_req_if.sink                         req_chan,
   ipl_rsp_if.source                       rsp_chan,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [ipl_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [ipl_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [ipl_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);

   logic [ipl_pkg::COUNT_W-1:0] count_sat;
   ipl_pkg::mem_req_type        mem_req;
   ipl_pkg::row_type            rd_row;

   ipl_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .count_sat   (count_sat)
   );

   ipl_table u_table (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_row  (rd_row)
   );

   ipl_search u_search (
      .clock     (clock),
      .reset     (reset),
      .count_sat (count_sat),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .mem_req   (mem_req),
      .rd_row    (rd_row)
   );

   // A query transfer makes the block busy on the next cycle
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && (req_chan.opcode == ipl_pkg::OP_QUERY))
      |=> !req_chan.ready)
      else $error("ready stayed high after a query transfer");

   // Below-first-entry results carry zero slot and offset
   a_below_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.status == ipl_pkg::ST_BELOW))
      |-> ((rsp_chan.match_slot == '0) && (rsp_chan.match_offset == '0)))
      else $error("below-first-entry result with nonzero slot or offset");

   // Beyond-range results carry zero offset
   a_beyond_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.status == ipl_pkg::ST_BEYOND))
      |-> (rsp_chan.match_offset == '0))
      else $error("beyond-range result with nonzero offset");

   // Searched count never exceeds the table depth
   a_count_sat: assert property (@(posedge clock) disable iff (reset)
      count_sat <= ipl_pkg::COUNT_W'(ipl_pkg::TABLE_DEPTH))
      else $error("searched count above table depth");

endmodule

FILE: rtl/core/ipl_csr.sv
// CSR block: APB-style access to the entry count register, with saturation.
module ipl_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [ipl_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [ipl_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [ipl_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready,
   output logic [ipl_pkg::COUNT_W-1:0]     count_sat
);

   logic [ipl_pkg::COUNT_W-1:0] count_ff, count_in;
   logic                        hit_count;
   logic                        wr_xfer;

   assign hit_count = (csr_paddr[2] == ipl_pkg::REG_ENTRY_COUNT);
   assign wr_xfer   = csr_psel && csr_penable && csr_pwrite;

   // Register write on the access cycle
   always_comb begin
      count_in = count_ff;
      if (wr_xfer && hit_count) begin
         count_in = csr_pwdata[ipl_pkg::COUNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Read back, zero-wait
   assign csr_pready = 1'b1;
   assign csr_prdata = hit_count ? ipl_pkg::CSR_DATA_W'(count_ff) : '0;

   // Clamp the searched count to the table depth
   assign count_sat = (count_ff > ipl_pkg::COUNT_W'(ipl_pkg::TABLE_DEPTH)) ?
                      ipl_pkg::COUNT_W'(ipl_pkg::TABLE_DEPTH) : count_ff;

endmodule

FILE: rtl/core/ipl_table.sv
// Range table memory: one write or one registered read per cycle.
module ipl_table (
   input  logic                 clock,
   input  ipl_pkg::mem_req_type mem_req,
   output ipl_pkg::row_type     rd_row
);

   ipl_pkg::row_type mem [ipl_pkg::TABLE_DEPTH];
   ipl_pkg::row_type rd_row_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.addr] <= mem_req.row;
      end
   end

   // Registered read port, holds its data between reads
   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rd_row_ff <= mem[mem_req.addr];
      end
   end

   assign rd_row = rd_row_ff;

endmodule

FILE: rtl/core/ipl_search.sv
// Search sequencer: binary search over the table with one shared comparator.
module ipl_search (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [ipl_pkg::COUNT_W-1:0] count_sat,
   ipl_req_if.sink                     req_chan,
   ipl_rsp_if.source                   rsp_chan,
   output ipl_pkg::mem_req_type        mem_req,
   input  ipl_pkg::row_type            rd_row
);

   typedef enum logic [4:0] {
      S_IDLE    = 5'b00001,
      S_PROBE   = 5'b00010,
      S_COMPARE = 5'b00100,
      S_FETCH   = 5'b01000,
      S_CHECK   = 5'b10000
   } state_type;

   state_type                           state_ff, state_in;
   logic [ipl_pkg::COUNT_W-1:0]         lo_ff, lo_in;
   logic signed [ipl_pkg::IDX_W-1:0]    hi_ff, hi_in;
   logic [ipl_pkg::ADDR_W-1:0]          addr_ff, addr_in;
   logic                                below_ff, below_in;

   logic                                rsp_valid_ff, rsp_valid_in;
   logic [ipl_pkg::STATUS_W-1:0]        status_ff, status_in;
   logic [ipl_pkg::SLOT_W-1:0]          slot_ff, slot_in;
   logic [ipl_pkg::OFF_W-1:0]           offset_ff, offset_in;

   logic                                req_xfer;
   logic                                out_free;
   logic [ipl_pkg::IDX_W-1:0]           mid_sum;
   logic [ipl_pkg::SLOT_W-1:0]          mid;
   logic [ipl_pkg::COUNT_W-1:0]         lo_next;
   logic signed [ipl_pkg::IDX_W-1:0]    hi_next;
   logic [ipl_pkg::ADDR_W-1:0]          cmp_a, cmp_b;
   logic                                cmp_gt;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_xfer       = req_chan.valid && req_chan.ready;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;

   // Probe index; lo and hi are both non-negative while probing
   assign mid_sum = ipl_pkg::IDX_W'(lo_ff) + ipl_pkg::IDX_W'(hi_ff);
   assign mid     = mid_sum[ipl_pkg::SLOT_W:1];

   // Shared comparator: start > address while probing, address > end at check
   always_comb begin
      if (state_ff == S_CHECK) begin
         cmp_a = addr_ff;
         cmp_b = rd_row.range_end;
      end else begin
         cmp_a = rd_row.range_start;
         cmp_b = addr_ff;
      end
   end
   assign cmp_gt = (cmp_a > cmp_b);

   // Bound update after a probe
   always_comb begin
      lo_next = lo_ff;
      hi_next = hi_ff;
      if (cmp_gt) begin
         hi_next = $signed(ipl_pkg::IDX_W'(mid)) - ipl_pkg::IDX_W'(1);
      end else begin
         lo_next = ipl_pkg::COUNT_W'(mid) + ipl_pkg::COUNT_W'(1);
      end
   end

   // Table access
   always_comb begin
      mem_req.wr_en                = 1'b0;
      mem_req.rd_en                = 1'b0;
      mem_req.addr                 = hi_ff[ipl_pkg::SLOT_W-1:0];
      mem_req.row.range_start      = req_chan.range_start;
      mem_req.row.range_end        = req_chan.range_end;
      mem_req.row.location_offset  = req_chan.location_offset;
      if (state_ff == S_IDLE) begin
         mem_req.addr  = req_chan.entry_slot;
         mem_req.wr_en = req_xfer && (req_chan.opcode == ipl_pkg::OP_LOAD);
      end else if (state_ff == S_PROBE) begin
         mem_req.addr  = mid;
         mem_req.rd_en = 1'b1;
      end else if (state_ff == S_FETCH) begin
         mem_req.rd_en = 1'b1;
      end
   end

   // Sequencer
   always_comb begin
      state_in  = state_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      addr_in   = addr_ff;
      below_in  = below_ff;
      status_in = status_ff;
      slot_in   = slot_ff;
      offset_in = offset_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer && (req_chan.opcode == ipl_pkg::OP_QUERY)) begin
               lo_in   = '0;
               hi_in   = $signed(ipl_pkg::IDX_W'(count_sat)) - ipl_pkg::IDX_W'(1);
               addr_in = req_chan.query_address;
               if (count_sat == '0) begin
                  below_in = 1'b1;
                  state_in = S_CHECK;
               end else begin
                  below_in = 1'b0;
                  state_in = S_PROBE;
               end
            end
         end
         S_PROBE: begin
            state_in = S_COMPARE;
         end
         S_COMPARE: begin
            lo_in = lo_next;
            hi_in = hi_next;
            if ($signed({1'b0, lo_next}) <= hi_next) begin
               state_in = S_PROBE;
            end else if (hi_next[ipl_pkg::IDX_W-1]) begin
               below_in = 1'b1;
               state_in = S_CHECK;
            end else begin
               state_in = S_FETCH;
            end
         end
         S_FETCH: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            // Issue the result once the output register is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
               if (below_ff) begin
                  status_in = ipl_pkg::ST_BELOW;
                  slot_in   = '0;
                  offset_in = '0;
               end else if (cmp_gt) begin
                  status_in = ipl_pkg::ST_BEYOND;
                  slot_in   = hi_ff[ipl_pkg::SLOT_W-1:0];
                  offset_in = '0;
               end else begin
                  status_in = ipl_pkg::ST_FOUND;
                  slot_in   = hi_ff[ipl_pkg::SLOT_W-1:0];
                  offset_in = rd_row.location_offset;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      addr_ff   <= addr_in;
      below_ff  <= below_in;
      status_ff <= status_in;
      slot_ff   <= slot_in;
      offset_ff <= offset_in;
   end

   // Output register
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = status_ff;
   assign rsp_chan.match_slot   = slot_ff;
   assign rsp_chan.match_offset = offset_ff;

endmodule
